### design/largest_blob_size_finder_defines.svh
// ----------------------------------------------------------------------------
// largest_blob_size_finder_defines
// Assertion macros shared by the blob size finder.
// ----------------------------------------------------------------------------
`ifndef LARGEST_BLOB_SIZE_FINDER_DEFINES_SVH
`define LARGEST_BLOB_SIZE_FINDER_DEFINES_SVH

// same-cycle implication
`define LBSF_ASSERT_IMP(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("lbsf check failed");

// next-cycle implication
`define LBSF_ASSERT_NXT(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("lbsf check failed");

`endif

### design/lbsf_pkg.sv
// ----------------------------------------------------------------------------
// lbsf_pkg
// Shared types and codes for the blob size finder.
// ----------------------------------------------------------------------------
package lbsf_pkg;

    typedef enum logic [1:0] {
        DIR_RIGHT,
        DIR_DOWN,
        DIR_UP,
        DIR_LEFT
    } nbr_dir_t;

    localparam logic [1:0] CELL_LAND = 2'd1;
    localparam logic [1:0] CELL_SEEN = 2'd2;

    localparam logic CFG_NUM_ROWS = 1'b0;
    localparam logic CFG_NUM_COLS = 1'b1;

    function automatic nbr_dir_t next_dir(nbr_dir_t d);
        nbr_dir_t n;
        case (d)
            DIR_RIGHT: n = DIR_DOWN;
            DIR_DOWN:  n = DIR_UP;
            DIR_UP:    n = DIR_LEFT;
            default:   n = DIR_RIGHT;
        endcase
        return n;
    endfunction

endpackage

### design/lbsf_ram.sv
// ----------------------------------------------------------------------------
// lbsf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lbsf_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4096,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### design/lbsf_nbr.sv
// ----------------------------------------------------------------------------
// lbsf_nbr
// Neighbor address unit: bounds check and index of one 4-connected neighbor.
// ----------------------------------------------------------------------------
module lbsf_nbr import lbsf_pkg::*; #(
    parameter int AW = 12,
    parameter int RB = 7,
    parameter int CB = 7,
    parameter int NW = 13
) (
    input  nbr_dir_t      dir,
    input  logic [AW-1:0] node,
    input  logic [RB-1:0] r,
    input  logic [CB-1:0] c,
    input  logic [RB-1:0] rows,
    input  logic [CB-1:0] cols,
    output logic          ok,
    output logic [AW-1:0] nidx,
    output logic [RB-1:0] nr,
    output logic [CB-1:0] nc
);

    logic [NW-1:0] node_w;
    logic [NW-1:0] cols_w;
    logic [NW-1:0] sum_w;
    logic [RB:0]   r_inc;
    logic [CB:0]   c_inc;

    always_comb
    begin
        node_w = NW'(node);
        cols_w = NW'(cols);
        r_inc  = {1'b0, r} + (RB+1)'(1);
        c_inc  = {1'b0, c} + (CB+1)'(1);
        ok     = 1'b0;
        sum_w  = node_w;
        nr     = r;
        nc     = c;
        case (dir)
            DIR_RIGHT:
            begin
                ok    = c_inc < {1'b0, cols};
                sum_w = node_w + NW'(1);
                nc    = c_inc[CB-1:0];
            end
            DIR_DOWN:
            begin
                ok    = r_inc < {1'b0, rows};
                sum_w = node_w + cols_w;
                nr    = r_inc[RB-1:0];
            end
            DIR_UP:
            begin
                ok    = r != '0;
                sum_w = node_w - cols_w;
                nr    = r - RB'(1);
            end
            default:
            begin
                ok    = c != '0;
                sum_w = node_w - NW'(1);
                nc    = c - CB'(1);
            end
        endcase
        nidx = sum_w[AW-1:0];
    end

endmodule

### design/largest_blob_size_finder.sv
// Loads one pixel per accepted beat; busy stays low while a frame streams in.
// After the last pixel, done rises once the scan and flood fill are through.
// The next pixel is accepted in the done cycle; the receiver cannot stall.
// Reset is asynchronous active low; RAM contents are not cleared.
// ----------------------------------------------------------------------------
// largest_blob_size_finder
// Breadth-first flood fill over a stored binary frame; reports the largest
// 4-connected land region.
// ----------------------------------------------------------------------------
`include "largest_blob_size_finder_defines.svh"

module largest_blob_size_finder import lbsf_pkg::*; #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        pixel,
    input  logic        last_pixel,
    output logic        done,
    output logic [12:0] largest_size,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_data
);

    localparam int CELL_CAP = MAX_ROWS * MAX_COLS;
    localparam int AW = (CELL_CAP > 1) ? $clog2(CELL_CAP) : 1;
    localparam int NW = $clog2(CELL_CAP + 1);
    localparam int RB = $clog2(MAX_ROWS + 1);
    localparam int CB = $clog2(MAX_COLS + 1);
    localparam int QW = AW + RB + CB;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_Q_RD,
        ST_Q_LATCH,
        ST_NB_RD,
        ST_NB_CHK
    } state_t;

    function automatic int clamp_dim(logic [6:0] v, int maxv);
        int res;
        if (v == 7'd0)
        begin
            res = 1;
        end
        else if (int'(v) > maxv)
        begin
            res = maxv;
        end
        else
        begin
            res = int'(v);
        end
        return res;
    endfunction

    state_t        state_reg, state_next;
    logic [6:0]    rows_cfg_reg, rows_cfg_next;
    logic [6:0]    cols_cfg_reg, cols_cfg_next;
    logic [RB-1:0] rows_reg, rows_next;
    logic [CB-1:0] cols_reg, cols_next;
    logic [NW-1:0] total_reg, total_next;
    logic [NW-1:0] load_reg, load_next;
    logic [NW-1:0] scan_reg, scan_next;
    logic [RB-1:0] sr_reg, sr_next;
    logic [CB-1:0] sc_reg, sc_next;
    logic [NW-1:0] head_reg, head_next;
    logic [NW-1:0] tail_reg, tail_next;
    logic [NW-1:0] region_reg, region_next;
    logic [NW-1:0] best_reg, best_next;
    logic [AW-1:0] node_reg, node_next;
    logic [RB-1:0] nr_reg, nr_next;
    logic [CB-1:0] nc_reg, nc_next;
    nbr_dir_t      dir_reg, dir_next;
    logic [AW-1:0] nidx_reg, nidx_next;
    logic [RB-1:0] nbr_r_reg, nbr_r_next;
    logic [CB-1:0] nbr_c_reg, nbr_c_next;
    logic          done_reg, done_next;
    logic [12:0]   size_reg, size_next;

    logic          cell_we;
    logic [AW-1:0] cell_waddr;
    logic [1:0]    cell_wdata;
    logic [AW-1:0] cell_raddr;
    logic [1:0]    cell_rdata;
    logic          q_we;
    logic [QW-1:0] q_wdata;
    logic [QW-1:0] q_rdata;

    logic          nb_ok;
    logic [AW-1:0] nb_idx;
    logic [RB-1:0] nb_r;
    logic [CB-1:0] nb_c;

    logic [CB:0]   sc_inc;

    lbsf_ram #(
        .WIDTH (2),
        .DEPTH (CELL_CAP),
        .AW    (AW)
    ) u_cell_ram (
        .clk   (clk),
        .we    (cell_we),
        .waddr (cell_waddr),
        .wdata (cell_wdata),
        .raddr (cell_raddr),
        .rdata (cell_rdata)
    );

    lbsf_ram #(
        .WIDTH (QW),
        .DEPTH (CELL_CAP),
        .AW    (AW)
    ) u_queue_ram (
        .clk   (clk),
        .we    (q_we),
        .waddr (tail_reg[AW-1:0]),
        .wdata (q_wdata),
        .raddr (head_reg[AW-1:0]),
        .rdata (q_rdata)
    );

    lbsf_nbr #(
        .AW (AW),
        .RB (RB),
        .CB (CB),
        .NW (NW)
    ) u_nbr (
        .dir  (dir_reg),
        .node (node_reg),
        .r    (nr_reg),
        .c    (nc_reg),
        .rows (rows_reg),
        .cols (cols_reg),
        .ok   (nb_ok),
        .nidx (nb_idx),
        .nr   (nb_r),
        .nc   (nb_c)
    );

    assign busy      = state_reg != ST_IDLE;
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign largest_size = size_reg;

    always_comb
    begin
        state_next    = state_reg;
        rows_cfg_next = rows_cfg_reg;
        cols_cfg_next = cols_cfg_reg;
        rows_next     = rows_reg;
        cols_next     = cols_reg;
        total_next    = total_reg;
        load_next     = load_reg;
        scan_next     = scan_reg;
        sr_next       = sr_reg;
        sc_next       = sc_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        region_next   = region_reg;
        best_next     = best_reg;
        node_next     = node_reg;
        nr_next       = nr_reg;
        nc_next       = nc_reg;
        dir_next      = dir_reg;
        nidx_next     = nidx_reg;
        nbr_r_next    = nbr_r_reg;
        nbr_c_next    = nbr_c_reg;
        done_next     = 1'b0;
        size_next     = size_reg;

        cell_we    = 1'b0;
        cell_waddr = load_reg[AW-1:0];
        cell_wdata = {1'b0, pixel};
        cell_raddr = scan_reg[AW-1:0];
        q_we       = 1'b0;
        q_wdata    = {scan_reg[AW-1:0], sr_reg, sc_reg};

        sc_inc = {1'b0, sc_reg} + (CB+1)'(1);

        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_NUM_ROWS: rows_cfg_next = cfg_data;
                CFG_NUM_COLS: cols_cfg_next = cfg_data;
                default:      rows_cfg_next = rows_cfg_reg;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (load_reg < NW'(CELL_CAP))
                    begin
                        cell_we   = 1'b1;
                        load_next = load_reg + NW'(1);
                    end
                    if (last_pixel)
                    begin
                        rows_next  = RB'(clamp_dim(rows_cfg_reg, MAX_ROWS));
                        cols_next  = CB'(clamp_dim(cols_cfg_reg, MAX_COLS));
                        state_next = ST_SETUP;
                    end
                end
            end
            ST_SETUP:
            begin
                total_next = NW'(rows_reg * cols_reg);
                scan_next  = '0;
                sr_next    = '0;
                sc_next    = '0;
                best_next  = '0;
                state_next = ST_SCAN_RD;
            end
            ST_SCAN_RD:
            begin
                if (scan_reg == total_reg)
                begin
                    done_next  = 1'b1;
                    size_next  = 13'(best_reg);
                    load_next  = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_SCAN_CHK;
                end
            end
            ST_SCAN_CHK:
            begin
                if (scan_reg < load_reg && cell_rdata == CELL_LAND)
                begin
                    cell_we     = 1'b1;
                    cell_waddr  = scan_reg[AW-1:0];
                    cell_wdata  = CELL_SEEN;
                    q_we        = 1'b1;
                    head_next   = '0;
                    tail_next   = NW'(1);
                    region_next = NW'(1);
                    state_next  = ST_Q_RD;
                end
                else
                begin
                    state_next = ST_SCAN_RD;
                end
            end
            ST_Q_RD:
            begin
                if (head_reg == tail_reg)
                begin
                    if (region_reg > best_reg)
                    begin
                        best_next = region_reg;
                    end
                    head_next  = '0;
                    tail_next  = '0;
                    state_next = ST_SCAN_RD;
                end
                else
                begin
                    head_next  = head_reg + NW'(1);
                    state_next = ST_Q_LATCH;
                end
            end
            ST_Q_LATCH:
            begin
                {node_next, nr_next, nc_next} = q_rdata;
                dir_next   = DIR_RIGHT;
                state_next = ST_NB_RD;
            end
            ST_NB_RD:
            begin
                cell_raddr = nb_idx;
                nidx_next  = nb_idx;
                nbr_r_next = nb_r;
                nbr_c_next = nb_c;
                if (nb_ok)
                begin
                    state_next = ST_NB_CHK;
                end
                else if (dir_reg == DIR_LEFT)
                begin
                    state_next = ST_Q_RD;
                end
                else
                begin
                    dir_next = next_dir(dir_reg);
                end
            end
            ST_NB_CHK:
            begin
                if (NW'(nidx_reg) < load_reg && cell_rdata == CELL_LAND)
                begin
                    cell_we     = 1'b1;
                    cell_waddr  = nidx_reg;
                    cell_wdata  = CELL_SEEN;
                    q_we        = 1'b1;
                    q_wdata     = {nidx_reg, nbr_r_reg, nbr_c_reg};
                    tail_next   = tail_reg + NW'(1);
                    region_next = region_reg + NW'(1);
                end
                if (dir_reg == DIR_LEFT)
                begin
                    state_next = ST_Q_RD;
                end
                else
                begin
                    dir_next   = next_dir(dir_reg);
                    state_next = ST_NB_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if ((state_reg == ST_SCAN_CHK && state_next == ST_SCAN_RD) ||
            (state_reg == ST_Q_RD && state_next == ST_SCAN_RD))
        begin
            scan_next = scan_reg + NW'(1);
            if (sc_inc == {1'b0, cols_reg})
            begin
                sc_next = '0;
                sr_next = sr_reg + RB'(1);
            end
            else
            begin
                sc_next = sc_inc[CB-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            rows_cfg_reg <= 7'd64;
            cols_cfg_reg <= 7'd64;
            load_reg     <= '0;
            head_reg     <= '0;
            tail_reg     <= '0;
            region_reg   <= '0;
            best_reg     <= '0;
            done_reg     <= 1'b0;
            size_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            rows_cfg_reg <= rows_cfg_next;
            cols_cfg_reg <= cols_cfg_next;
            load_reg     <= load_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            region_reg   <= region_next;
            best_reg     <= best_next;
            done_reg     <= done_next;
            size_reg     <= size_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rows_reg  <= rows_next;
        cols_reg  <= cols_next;
        total_reg <= total_next;
        scan_reg  <= scan_next;
        sr_reg    <= sr_next;
        sc_reg    <= sc_next;
        node_reg  <= node_next;
        nr_reg    <= nr_next;
        nc_reg    <= nc_next;
        dir_reg   <= dir_next;
        nidx_reg  <= nidx_next;
        nbr_r_reg <= nbr_r_next;
        nbr_c_reg <= nbr_c_next;
    end

    `LBSF_ASSERT_IMP(a_done_idle, done, !busy)
    `LBSF_ASSERT_NXT(a_last_busy, start && !busy && last_pixel, busy)
    `LBSF_ASSERT_NXT(a_done_single, done, !done)
    `LBSF_ASSERT_IMP(a_queue_order, busy, head_reg <= tail_reg)

endmodule

### test/largest_blob_size_finder_tb.sv
// ----------------------------------------------------------------------------
// largest_blob_size_finder_tb
// Streams binary frames into the blob size finder and checks every reported
// region size against a flood-fill predictor: reset dimensions, clamped and
// extreme dimensions, stray pixels past the frame, and random frames with
// random gaps on the pixel stream.
// ----------------------------------------------------------------------------
module largest_blob_size_finder_tb import lbsf_pkg::*; ();

    localparam int          MAX_ROWS      = 64;
    localparam int          MAX_COLS      = 64;
    localparam int unsigned CELL_CAP      = MAX_ROWS * MAX_COLS;
    localparam int unsigned RANDOM_PIXELS = 1920;
    localparam int unsigned SETTLE_CYCLES = 16;
    localparam int unsigned END_CYCLES    = 200;
    localparam int unsigned LIMIT_CYCLES  = 100_000_000;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        start      = 1'b0;
    logic        pixel      = 1'b0;
    logic        last_pixel = 1'b0;
    logic        cfg_valid  = 1'b0;
    logic        cfg_index  = CFG_NUM_ROWS;
    logic [6:0]  cfg_data   = 7'd0;
    logic        busy;
    logic        done;
    logic [12:0] largest_size;
    logic        cfg_ready;

    logic [6:0]  rows_reg = 7'd64;
    logic [6:0]  cols_reg = 7'd64;
    bit          frame_px [CELL_CAP];
    int unsigned load_count;
    int unsigned size_expect_q [$];
    logic [12:0] want_size;

    int unsigned fail_count;
    int unsigned pixels_sent;
    int unsigned frames_sent;
    int unsigned frames_checked;
    int unsigned biggest_seen;
    int unsigned cycle_count;
    bit          burst_mode;

    largest_blob_size_finder i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .pixel        (pixel),
        .last_pixel   (last_pixel),
        .done         (done),
        .largest_size (largest_size),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (size_expect_q.size() == 0)
            begin
                $error("largest_size beat with no frame pending: got %0d", largest_size);
                fail_count++;
            end
            else
            begin
                want_size = 13'(size_expect_q.pop_front());
                frames_checked++;
                if (largest_size !== want_size)
                begin
                    $error("largest_size expected %0d actual %0d", want_size, largest_size);
                    fail_count++;
                end
            end
        end
    end

    function automatic int unsigned clamp_dim(input logic [6:0] v, input int unsigned maxv);
        if (v == 7'd0)
            return 1;
        if (v > maxv)
            return maxv;
        return 32'(v);
    endfunction

    function automatic int unsigned largest_region();
        int unsigned eff_r;
        int unsigned eff_c;
        int unsigned total;
        int unsigned head;
        int unsigned tail;
        int unsigned node;
        int unsigned row;
        int unsigned col;
        int unsigned nb;
        int unsigned sz;
        int unsigned best;
        bit          ok;
        bit          seen [CELL_CAP];
        int unsigned fifo [CELL_CAP];
        eff_r = clamp_dim(rows_reg, MAX_ROWS);
        eff_c = clamp_dim(cols_reg, MAX_COLS);
        total = eff_r * eff_c;
        best  = 0;
        for (int unsigned s = 0; s < total; s++)
        begin
            if (s < load_count && frame_px[s] && !seen[s])
            begin
                seen[s] = 1'b1;
                fifo[0] = s;
                head    = 0;
                tail    = 1;
                sz      = 1;
                while (head < tail)
                begin
                    node = fifo[head];
                    head++;
                    row  = node / eff_c;
                    col  = node % eff_c;
                    for (int d = 0; d < 4; d++)
                    begin
                        case (nbr_dir_t'(d))
                            DIR_RIGHT:
                            begin
                                ok = (col + 1 < eff_c);
                                nb = node + 1;
                            end
                            DIR_DOWN:
                            begin
                                ok = (row + 1 < eff_r);
                                nb = node + eff_c;
                            end
                            DIR_UP:
                            begin
                                ok = (row > 0);
                                nb = node - eff_c;
                            end
                            default:
                            begin
                                ok = (col > 0);
                                nb = node - 1;
                            end
                        endcase
                        if (ok && nb < load_count && frame_px[nb] && !seen[nb])
                        begin
                            seen[nb]   = 1'b1;
                            fifo[tail] = nb;
                            tail++;
                            sz++;
                        end
                    end
                end
                if (sz > best)
                    best = sz;
            end
        end
        return best;
    endfunction

    function automatic void absorb_pixel(input logic px, input logic lst);
        int unsigned sz;
        if (load_count < CELL_CAP)
        begin
            frame_px[load_count] = px;
            load_count++;
        end
        if (lst)
        begin
            sz = largest_region();
            size_expect_q = {size_expect_q, sz};
            if (sz > biggest_seen)
                biggest_seen = sz;
            load_count = 0;
            frames_sent++;
        end
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (burst_mode || r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [6:0] pick_dim();
        int unsigned sel;
        sel = $urandom_range(0, 19);
        if (sel == 0)
            return $urandom_range(0, 1) ? 7'd0 : 7'($urandom_range(65, 127));
        if (sel == 1)
            return 7'($urandom_range(17, 64));
        if (sel < 5)
            return 7'($urandom_range(9, 16));
        return 7'($urandom_range(1, 8));
    endfunction

    task automatic send_pixel(input logic px, input logic lst);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        pixel      <= px;
        last_pixel <= lst;
        do
            @(posedge clk);
        while (busy);
        absorb_pixel(px, lst);
        pixels_sent++;
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (size_expect_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_dims(input logic [6:0] r, input logic [6:0] c);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_NUM_ROWS;
        cfg_data  <= r;
        do
            @(posedge clk);
        while (!cfg_ready);
        rows_reg = r;
        cfg_index <= CFG_NUM_COLS;
        cfg_data  <= c;
        do
            @(posedge clk);
        while (!cfg_ready);
        cols_reg = c;
        cfg_valid <= 1'b0;
    endtask

    task automatic send_frame(input logic [31:0] bits, input int unsigned len);
        for (int unsigned i = 0; i < len; i++)
            send_pixel(bits[i], i == len - 1);
    endtask

    task automatic test_reset_defaults();
        send_frame(32'b1011, 4);
        send_frame(32'b0, 1);
    endtask

    task automatic test_clamped_dims();
        wait_idle();
        write_dims(7'd0, 7'd0);
        send_frame(32'b1, 1);
        wait_idle();
        write_dims(7'd127, 7'd127);
        send_frame(32'b10111, 5);
        wait_idle();
        write_dims(7'd1, 7'd64);
        send_frame(32'b1101, 4);
        wait_idle();
        write_dims(7'd64, 7'd1);
        send_frame(32'b1011, 4);
    endtask

    task automatic test_stray_pixels();
        wait_idle();
        write_dims(7'd2, 7'd3);
        send_frame(32'b11100011, 8);
    endtask

    task automatic test_random_frames();
        int unsigned first;
        int unsigned area;
        int unsigned len;
        int unsigned dens;
        int unsigned kind;
        first = pixels_sent;
        while (pixels_sent - first < RANDOM_PIXELS)
        begin
            if ($urandom_range(0, 1))
            begin
                wait_idle();
                write_dims(pick_dim(), pick_dim());
            end
            burst_mode = ($urandom_range(0, 3) == 0);
            area = clamp_dim(rows_reg, MAX_ROWS) * clamp_dim(cols_reg, MAX_COLS);
            kind = $urandom_range(0, 9);
            if (area > 256)
                len = $urandom_range(1, 256);
            else if (kind < 7)
                len = area;
            else if (kind < 9)
                len = $urandom_range(1, area);
            else
                len = area + $urandom_range(1, 8);
            case ($urandom_range(0, 5))
                0:       dens = 10;
                1:       dens = 30;
                2:       dens = 50;
                3:       dens = 60;
                4:       dens = 80;
                default: dens = 100;
            endcase
            for (int unsigned i = 0; i < len; i++)
                send_pixel($urandom_range(0, 99) < dens, i == len - 1);
        end
        burst_mode = 1'b0;
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_clamped_dims();
        test_stray_pixels();
        test_random_frames();
        wait_idle();
        repeat (END_CYCLES) @(posedge clk);
        if (size_expect_q.size() != 0)
        begin
            $error("largest_size expected %0d actual none", size_expect_q[0]);
            fail_count++;
        end
        $display("Covered %0d frames (%0d checked) from %0d pixels, largest region %0d.",
                 frames_sent, frames_checked, pixels_sent, biggest_seen);
        $display("Included clamped, stray-pixel, short and overlong frames.");
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
